[rtl/dhoat_pkg.sv]
// Shared types, codes and constants for the double-hashing open-address table.
// Used by dhoat_ctrl, dhoat_dp and double_hash_open_address_table.
// No dependencies.
package dhoat_pkg;

  // Default parameter values
  localparam int DEFAULT_TABLE_DEPTH  = 1024;
  localparam int DEFAULT_PAYLOAD_BITS = 32;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int KEY_W      = 64;
  localparam int CODE_W     = 24;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 11;
  localparam int HEAVY_W    = 20;
  localparam int SUM_W      = 32;
  localparam int TSIZE_W    = 11;
  localparam int PRIME_W    = 10;
  localparam int STEP_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_CNT_W  = 7;

  // Probe arithmetic and statistics constants
  localparam int STEP_BASE   = 10;
  localparam int HEAVY_LIMIT = 10;
  localparam int SIZE_MIN    = 3;

  // Register reset values
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = 11'd1021;
  localparam logic [PRIME_W-1:0] PRIME_RESET = 10'd1019;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PRIME = 2'd1;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Slot states
  localparam logic [1:0] SLOT_FREE = 2'd0;
  localparam logic [1:0] SLOT_USED = 2'd1;
  localparam logic [1:0] SLOT_GONE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_STEP_LOAD,
    S_STEP_DIV,
    S_PROBE_SETUP,
    S_PROBE_RD,
    S_PROBE_EV,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic div_run;
    logic mod_load;
    logic pos_init;
    logic eval;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic hit_stop;
    logic op_none;
    logic out_free;
  } sts_t;

endpackage

[rtl/dhoat_ctrl.sv]
// Sequencer for the hash table: clearing pass, division, probe loop, result hand-off.
// Depends on dhoat_pkg.
module dhoat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dhoat_pkg::sts_t sts,
  output dhoat_pkg::cmd_t cmd
);
  import dhoat_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:       if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:        if (in_valid) state_nxt = sts.op_none ? S_DONE : S_DIVIDE;
      S_DIVIDE:      if (sts.div_last) state_nxt = S_STEP_LOAD;
      S_STEP_LOAD:   state_nxt = S_STEP_DIV;
      S_STEP_DIV:    if (sts.div_last) state_nxt = S_PROBE_SETUP;
      S_PROBE_SETUP: state_nxt = S_PROBE_RD;
      S_PROBE_RD:    state_nxt = S_PROBE_EV;
      S_PROBE_EV:    state_nxt = sts.hit_stop ? S_DONE : S_PROBE_RD;
      S_DONE:        if (sts.out_free) state_nxt = S_IDLE;
      default:       state_nxt = S_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR:       cmd.clr_en = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DIVIDE:      cmd.div_run = 1'b1;
      S_STEP_LOAD:   cmd.mod_load = 1'b1;
      S_STEP_DIV:    cmd.div_run = 1'b1;
      S_PROBE_SETUP: cmd.pos_init = 1'b1;
      S_PROBE_RD:    cmd = '0;
      S_PROBE_EV:    cmd.eval = 1'b1;
      S_DONE:        cmd.out_load = sts.out_free;
      default:       cmd = '0;
    endcase
  end

endmodule

[rtl/dhoat_dp.sv]
// Datapath: config registers, shared restoring divider, slot memories, statistics, result.
// Depends on dhoat_pkg.
module dhoat_dp #(
  parameter int TABLE_DEPTH  = dhoat_pkg::DEFAULT_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = dhoat_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dhoat_pkg::cmd_t                  cmd,
  output dhoat_pkg::sts_t                  sts,
  input  logic                             cfg_we,
  input  logic [dhoat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhoat_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [dhoat_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [dhoat_pkg::KEY_W-1:0]      in_search_key,
  input  logic [dhoat_pkg::CODE_W-1:0]     in_entry_code,
  input  logic [dhoat_pkg::DATA_W-1:0]     in_payload_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dhoat_pkg::STATUS_W-1:0]   out_status,
  output logic [dhoat_pkg::DATA_W-1:0]     out_payload_out,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_probe_count,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_element_total,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_worst_collisions,
  output logic [dhoat_pkg::HEAVY_W-1:0]    out_over_ten_inserts,
  output logic [dhoat_pkg::SUM_W-1:0]      out_collision_total
);
  import dhoat_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int PW    = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
  localparam int REC_W = CODE_W + PW;

  // Configuration
  logic [TSIZE_W-1:0] tsize_r;
  logic [PRIME_W-1:0] prime_r;
  logic [CNT_W-1:0]   size_eff;
  logic [PRIME_W-1:0] prime_eff;

  // Current item
  logic [OPCODE_W-1:0] op_r;
  logic [CODE_W-1:0]   code_r;
  logic [PW-1:0]       data_r;
  logic [CNT_W-1:0]    size_r;
  logic [PRIME_W-1:0]  prime_q_r;

  // Divider
  logic [KEY_W-1:0]     div_q_r;
  logic [CNT_W-1:0]     rs_r, rs_nxt;
  logic [PRIME_W-1:0]   rp_r, rp_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       rs_t;
  logic [PRIME_W:0]     rp_t;
  logic [STEP_W-1:0]    step_full;

  // Probe
  logic [IDX_W-1:0] base_r, stepm_r, pos_r, pos_adv, clr_idx_r;
  logic [CNT_W-1:0] pos_sum;
  logic [CNT_W-1:0] hits_r;

  // Memories
  logic [1:0]       st_mem [TABLE_DEPTH];
  logic [REC_W-1:0] rec_mem [TABLE_DEPTH];
  logic [1:0]       st_rd_r;
  logic [REC_W-1:0] rec_rd_r;
  logic [CODE_W-1:0] rd_code;
  logic [PW-1:0]     rd_data;

  // Evaluation
  logic                stop, exhaust, wr_st, wr_rec, ins_ok, del_ok, look_ok, code_hit;
  logic [1:0]          st_new;
  logic [STATUS_W-1:0] ev_status;

  // Statistics and result
  logic [CNT_W-1:0]    occ_r, peak_r;
  logic [SUM_W-1:0]    sum_r;
  logic [HEAVY_W-1:0]  heavy_r;
  logic [SUM_W:0]      sum_ext;
  logic [STATUS_W-1:0] res_status_r;
  logic [DATA_W-1:0]   res_data_r;
  logic                out_valid_r;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= TSIZE_RESET;
      prime_r <= PRIME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_TABLE_SIZE) tsize_r <= cfg_wdata;
      if (cfg_index == REG_STEP_PRIME) prime_r <= cfg_wdata[PRIME_W-1:0];
    end
  end

  // Effective size and prime
  always_comb begin
    if (tsize_r < TSIZE_W'(SIZE_MIN)) size_eff = CNT_W'(SIZE_MIN);
    else if (32'(tsize_r) > 32'(TABLE_DEPTH)) size_eff = CNT_W'(TABLE_DEPTH);
    else size_eff = CNT_W'(tsize_r);
    prime_eff = (prime_r == '0) ? PRIME_W'(1) : prime_r;
  end

  // One restoring step per cycle for both remainders
  assign rs_t      = {rs_r, div_q_r[KEY_W-1]};
  assign rp_t      = {rp_r, div_q_r[KEY_W-1]};
  assign rs_nxt    = (rs_t >= {1'b0, size_r}) ? CNT_W'(rs_t - {1'b0, size_r}) : CNT_W'(rs_t);
  assign rp_nxt    = (rp_t >= {1'b0, prime_q_r}) ? PRIME_W'(rp_t - {1'b0, prime_q_r})
                                                 : PRIME_W'(rp_t);
  assign step_full = STEP_W'(STEP_BASE) + STEP_W'(rp_r);

  // Next probe position, kept below size
  assign pos_sum = {1'b0, pos_r} + {1'b0, stepm_r};
  assign pos_adv = (pos_sum >= size_r) ? IDX_W'(pos_sum - size_r) : IDX_W'(pos_sum);

  assign rd_code  = rec_rd_r[REC_W-1:PW];
  assign rd_data  = rec_rd_r[PW-1:0];
  assign code_hit = (rd_code == code_r);

  // Slot decision
  always_comb begin
    stop      = 1'b0;
    wr_st     = 1'b0;
    wr_rec    = 1'b0;
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    look_ok   = 1'b0;
    st_new    = SLOT_USED;
    ev_status = ST_OK;
    case (op_r)
      OP_INSERT: begin
        if (st_rd_r != SLOT_USED) begin
          stop   = 1'b1;
          wr_st  = 1'b1;
          wr_rec = 1'b1;
          ins_ok = 1'b1;
        end else if (code_hit) begin
          stop      = 1'b1;
          ev_status = ST_DUPLICATE;
        end
      end
      OP_DELETE: begin
        if (st_rd_r == SLOT_USED && code_hit) begin
          stop   = 1'b1;
          wr_st  = 1'b1;
          st_new = SLOT_GONE;
          del_ok = 1'b1;
        end else if (st_rd_r == SLOT_FREE) begin
          stop      = 1'b1;
          ev_status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (st_rd_r == SLOT_USED && code_hit) begin
          stop    = 1'b1;
          look_ok = 1'b1;
        end else if (st_rd_r == SLOT_FREE) begin
          stop      = 1'b1;
          ev_status = ST_NOT_FOUND;
        end
      end
      default: stop = 1'b1;
    endcase
    exhaust = !stop && ((hits_r + CNT_W'(1)) == size_r);
  end

  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(hits_r);

  // Status to controller
  assign sts.clr_last = (clr_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.div_last = (div_cnt_r == DIV_CNT_W'(1));
  assign sts.hit_stop = stop || exhaust;
  assign sts.op_none  = (in_opcode != OP_INSERT) && (in_opcode != OP_DELETE) &&
                        (in_opcode != OP_LOOKUP);
  assign sts.out_free = !out_valid_r || out_ready;

  // Slot memories, registered reads
  always_ff @(posedge clk) begin
    st_rd_r  <= st_mem[pos_r];
    rec_rd_r <= rec_mem[pos_r];
    if (cmd.clr_en) begin
      st_mem[clr_idx_r] <= SLOT_FREE;
    end else if (cmd.eval && wr_st) begin
      st_mem[pos_r] <= st_new;
    end
    if (cmd.eval && wr_rec) begin
      rec_mem[pos_r] <= {code_r, data_r};
    end
  end

  // Clearing pass index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_en) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
    end
  end

  // Item capture, divider and probe walk
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_opcode;
      code_r    <= in_entry_code;
      data_r    <= in_payload_in[PW-1:0];
      size_r    <= size_eff;
      prime_q_r <= prime_eff;
      div_q_r   <= in_search_key;
      rs_r      <= '0;
      rp_r      <= '0;
      div_cnt_r <= DIV_CNT_W'(KEY_W);
      hits_r    <= '0;
    end
    if (cmd.div_run) begin
      div_q_r   <= {div_q_r[KEY_W-2:0], 1'b0};
      rs_r      <= rs_nxt;
      rp_r      <= rp_nxt;
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    // second pass reduces the step modulo the size
    if (cmd.mod_load) begin
      base_r    <= rs_r[IDX_W-1:0];
      div_q_r   <= {step_full, (KEY_W - STEP_W)'(0)};
      rs_r      <= '0;
      div_cnt_r <= DIV_CNT_W'(STEP_W);
    end
    if (cmd.pos_init) begin
      pos_r   <= base_r;
      stepm_r <= rs_r[IDX_W-1:0];
    end
    if (cmd.eval && !stop) begin
      pos_r  <= pos_adv;
      hits_r <= hits_r + CNT_W'(1);
    end
  end

  // Result of the current item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= ST_NOT_FOUND;
      res_data_r   <= '0;
    end
    if (cmd.eval) begin
      if (stop) begin
        res_status_r <= ev_status;
        if (look_ok) res_data_r <= DATA_W'(rd_data);
      end else if (exhaust) begin
        res_status_r <= (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      end
    end
  end

  // Occupancy and insert statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      peak_r  <= '0;
      sum_r   <= '0;
      heavy_r <= '0;
    end else if (cmd.eval) begin
      if (ins_ok) begin
        occ_r <= occ_r + CNT_W'(1);
        sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (hits_r > peak_r) peak_r <= hits_r;
        if (hits_r > CNT_W'(HEAVY_LIMIT) && heavy_r != '1) heavy_r <= heavy_r + HEAVY_W'(1);
      end
      if (del_ok) occ_r <= occ_r - CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status           <= res_status_r;
      out_payload_out      <= res_data_r;
      out_probe_count      <= CNT_OUT_W'(hits_r);
      out_element_total    <= CNT_OUT_W'(occ_r);
      out_worst_collisions <= CNT_OUT_W'(peak_r);
      out_over_ten_inserts <= heavy_r;
      out_collision_total  <= sum_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> ({1'b0, pos_r} < size_r))
    else $error("probe position outside table");

  a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> (hits_r < size_r))
    else $error("probe run longer than table");

  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy above depth");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (sum_r >= $past(sum_r)))
    else $error("collision sum decreased");
`endif

endmodule

[rtl/double_hash_open_address_table.sv]
// Double-hashing open-address table. After the input transfer it computes both key
// remainders, loads the step and reduces it modulo the size, sets up the probe, reads
// (registered) and then evaluates each probed slot, and loads the result register.
// One item at a time; opcode 3 skips the division and probe loop. The next item is taken
// while the previous result waits. After synchronous reset a clearing pass marks all
// TABLE_DEPTH slots free, one per cycle, with in_ready low; config writes are taken throughout.
// Depends on dhoat_pkg, dhoat_ctrl and dhoat_dp.
module double_hash_open_address_table #(
  parameter int TABLE_DEPTH  = dhoat_pkg::DEFAULT_TABLE_DEPTH,
  parameter int PAYLOAD_BITS = dhoat_pkg::DEFAULT_PAYLOAD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dhoat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhoat_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dhoat_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [dhoat_pkg::KEY_W-1:0]      in_search_key,
  input  logic [dhoat_pkg::CODE_W-1:0]     in_entry_code,
  input  logic [dhoat_pkg::DATA_W-1:0]     in_payload_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dhoat_pkg::STATUS_W-1:0]   out_status,
  output logic [dhoat_pkg::DATA_W-1:0]     out_payload_out,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_probe_count,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_element_total,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]  out_worst_collisions,
  output logic [dhoat_pkg::HEAVY_W-1:0]    out_over_ten_inserts,
  output logic [dhoat_pkg::SUM_W-1:0]      out_collision_total
);
  import dhoat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  dhoat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath and slot store
  dhoat_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_opcode            (in_opcode),
    .in_search_key        (in_search_key),
    .in_entry_code        (in_entry_code),
    .in_payload_in        (in_payload_in),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_payload_out      (out_payload_out),
    .out_probe_count      (out_probe_count),
    .out_element_total    (out_element_total),
    .out_worst_collisions (out_worst_collisions),
    .out_over_ten_inserts (out_over_ten_inserts),
    .out_collision_total  (out_collision_total)
  );

endmodule

[tb/sv/tb_double_hash_open_address_table.sv]
// Testbench for double_hash_open_address_table: directed and random table operations,
// each result checked against a behavioural model of the table held in the bench.
// Depends on dhoat_pkg and the RTL of the block.
module tb_double_hash_open_address_table;
  import dhoat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 40000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [DATA_W-1:0]    payload;
    logic [CNT_OUT_W-1:0] probes;
    logic [CNT_OUT_W-1:0] elements;
    logic [CNT_OUT_W-1:0] worst;
    logic [HEAVY_W-1:0]   heavy;
    logic [SUM_W-1:0]     coll_sum;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [KEY_W-1:0] in_search_key = '0;
  logic [CODE_W-1:0] in_entry_code = '0;
  logic [DATA_W-1:0] in_payload_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0] out_payload_out;
  logic [CNT_OUT_W-1:0] out_probe_count, out_element_total, out_worst_collisions;
  logic [HEAVY_W-1:0] out_over_ten_inserts;
  logic [SUM_W-1:0] out_collision_total;

  // Model state
  logic [TSIZE_W-1:0] mdl_size;
  logic [PRIME_W-1:0] mdl_prime;
  logic [1:0]         mdl_slot_st [DEPTH];
  logic [CODE_W-1:0]  mdl_slot_code [DEPTH];
  logic [DATA_W-1:0]  mdl_slot_data [DEPTH];
  int unsigned        mdl_occupied, mdl_peak, mdl_heavy;
  logic [SUM_W-1:0]   mdl_sum;

  table_result_t pending_results[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  out_wait = 0;
  bit  done_flag = 1'b0;
  logic [KEY_W-1:0] used_keys[$];
  logic [CODE_W-1:0] used_codes[$];

  always #5 clk = ~clk;

  double_hash_open_address_table i_dut (.*);

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Predict the result of one operation and update the model table
  function automatic table_result_t predict_operation(input logic [OPCODE_W-1:0] op,
      input logic [KEY_W-1:0] key, input logic [CODE_W-1:0] code,
      input logic [DATA_W-1:0] data);
    table_result_t r;
    int unsigned sz, pr, hits, pos;
    longint unsigned base, stride;
    bit stop;
    sz = (mdl_size < SIZE_MIN) ? SIZE_MIN : ((mdl_size > DEPTH) ? DEPTH : mdl_size);
    pr = (mdl_prime == 0) ? 1 : mdl_prime;
    base = key % sz;
    stride = STEP_BASE + key % pr;
    hits = 0;
    stop = 1'b0;
    r = '0;
    r.status = ST_NOT_FOUND;
    if (op <= OP_LOOKUP) begin
      while (!stop && hits < sz) begin
        pos = 32'((base + 64'(hits) * stride) % sz);
        if (op == OP_INSERT) begin
          if (mdl_slot_st[pos] != SLOT_USED) begin
            mdl_slot_st[pos] = SLOT_USED;
            mdl_slot_code[pos] = code;
            mdl_slot_data[pos] = data;
            mdl_occupied++;
            if (longint'(mdl_sum) + hits > 64'hFFFF_FFFF) mdl_sum = '1;
            else mdl_sum = mdl_sum + SUM_W'(hits);
            if (hits > mdl_peak) mdl_peak = hits;
            if (hits > HEAVY_LIMIT && mdl_heavy < 20'hFFFFF) mdl_heavy++;
            r.status = ST_OK;
            stop = 1'b1;
          end else if (mdl_slot_code[pos] == code) begin
            r.status = ST_DUPLICATE;
            stop = 1'b1;
          end
        end else begin
          if (mdl_slot_st[pos] == SLOT_USED && mdl_slot_code[pos] == code) begin
            if (op == OP_DELETE) begin
              mdl_slot_st[pos] = SLOT_GONE;
              mdl_occupied--;
            end else begin
              r.payload = mdl_slot_data[pos];
            end
            r.status = ST_OK;
            stop = 1'b1;
          end else if (mdl_slot_st[pos] == SLOT_FREE) begin
            stop = 1'b1;
          end
        end
        if (!stop) hits++;
      end
      if (!stop) r.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
    end
    r.probes = CNT_OUT_W'(hits);
    r.elements = CNT_OUT_W'(mdl_occupied);
    r.worst = CNT_OUT_W'(mdl_peak);
    r.heavy = HEAVY_W'(mdl_heavy);
    r.coll_sum = mdl_sum;
    return r;
  endfunction

  // Send one operation: random gap, then hold valid until the transfer
  task automatic send_operation(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [CODE_W-1:0] code, input logic [DATA_W-1:0] data);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_search_key <= key;
    in_entry_code <= code;
    in_payload_in <= data;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_operation(op, key, code, data));
  endtask

  // One register write, then cfg_we held low before returning so back-to-back writes stay apart
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TABLE_SIZE) mdl_size = TSIZE_W'(val);
    else mdl_prime = PRIME_W'(val);
    @(posedge clk);
  endtask

  // Wait for the block to drain before touching the registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result checker; ready rises after a random wait drawn for each result
  always @(posedge clk) begin
    table_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_payload_out !== w.payload)
          report_mismatch("payload_out", out_payload_out, w.payload);
        if (out_probe_count !== w.probes)
          report_mismatch("probe_count", out_probe_count, w.probes);
        if (out_element_total !== w.elements)
          report_mismatch("element_total", out_element_total, w.elements);
        if (out_worst_collisions !== w.worst)
          report_mismatch("worst_collisions", out_worst_collisions, w.worst);
        if (out_over_ten_inserts !== w.heavy)
          report_mismatch("over_ten_inserts", out_over_ten_inserts, w.heavy);
        if (out_collision_total !== w.coll_sum)
          report_mismatch("collision_total", out_collision_total, w.coll_sum);
      end
      out_ready <= 1'b0;
      out_wait = $urandom_range(0, 14);
    end else if (rst_n && out_valid && !out_ready) begin
      if (out_wait == 0) out_ready <= 1'b1;
      else out_wait--;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !done_flag) begin
      $display("double_hash_open_address_table verification failed");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Random operations, mostly on remembered records, so lookups and deletes hit
  task automatic run_mix(input int count, input int key_pool);
    logic [KEY_W-1:0] k;
    logic [CODE_W-1:0] c;
    int sel, n;
    for (int i = 0; i < count; i++) begin
      n = used_keys.size();
      if (n != 0 && $urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, n - 1);
        k = used_keys[sel];
        c = used_codes[sel];
        if ($urandom_range(0, 5) == 0) c = c ^ (24'h1 << $urandom_range(0, 23));
      end else begin
        k = (key_pool != 0) ? $urandom_range(0, key_pool) : rand_key();
        c = CODE_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                              : $urandom() & 24'hFFFFFF);
        used_keys.insert(used_keys.size(), k);
        used_codes.insert(used_codes.size(), c);
        if (used_keys.size() > 64) begin
          void'(used_keys.pop_front());
          void'(used_codes.pop_front());
        end
      end
      send_operation($urandom_range(0, 9) == 0 ? OP_UNUSED
                                               : OPCODE_W'($urandom_range(0, 2)),
                     k, c, $urandom());
    end
  endtask

  task automatic test_field_extremes();
    send_operation(OP_INSERT, '1, '1, '1);
    send_operation(OP_LOOKUP, '1, '1, '0);
    send_operation(OP_INSERT, '1, '1, 32'h1);
    send_operation(OP_INSERT, '0, '0, '0);
    send_operation(OP_LOOKUP, '0, '0, '1);
    send_operation(OP_DELETE, '1, '1, '0);
    send_operation(OP_LOOKUP, '1, '1, '0);
    send_operation(OP_DELETE, 64'h5555_5555_5555_5555, 24'hAAAAAA, '0);
    send_operation(OP_UNUSED, '1, '1, '1);
    send_operation(OP_INSERT, '1, 24'h123456, 32'hA5A5_5A5A);
    wait_quiet();
  endtask

  // Tiny table: fill until full, then exhausted searches
  task automatic test_small_table();
    write_register(REG_TABLE_SIZE, 0);
    write_register(REG_STEP_PRIME, 0);
    for (int i = 0; i < 5; i++) begin
      send_operation(OP_INSERT, KEY_W'(i), CODE_W'(24'h100 + i), $urandom());
    end
    send_operation(OP_LOOKUP, 7, 24'hFFFF00, 0);
    send_operation(OP_DELETE, 1, 24'h101, 0);
    send_operation(OP_INSERT, 2, 24'h777, 1);
    send_operation(OP_LOOKUP, 2, 24'h777, 0);
    wait_quiet();
    // Oversized size, clamped to the table depth, over the existing records
    write_register(REG_TABLE_SIZE, 2047);
    write_register(REG_STEP_PRIME, 1023);
    wait_quiet();
  endtask

  // Given table size and prime with clustered keys for long probe runs and statistics
  task automatic test_clustered(input int unsigned sz, input int unsigned pr, input int n);
    write_register(REG_TABLE_SIZE, sz);
    write_register(REG_STEP_PRIME, pr);
    used_keys.delete();
    used_codes.delete();
    run_mix(n, 4 * sz);
    wait_quiet();
  endtask

  initial begin
    mdl_size = TSIZE_RESET;
    mdl_prime = PRIME_RESET;
    foreach (mdl_slot_st[i]) mdl_slot_st[i] = SLOT_FREE;
    mdl_occupied = 0;
    mdl_peak = 0;
    mdl_heavy = 0;
    mdl_sum = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_small_table();
    test_clustered(31, 29, 100);
    test_clustered(13, 11, 70);
    test_clustered(1021, 1019, 100);
    test_clustered(61, 2, 90);
    test_clustered(17, 13, 60);
    test_clustered(1024, 1, 40);
    done_flag = 1'b0;
    wait_quiet();
    repeat (200) @(posedge clk);
    done_flag = 1'b1;
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("double_hash_open_address_table verification clean");
    end else begin
      $display("double_hash_open_address_table verification failed");
    end
    $finish;
  end
endmodule
